/* src/tst_pkg.sv */
`timescale 1ns / 1ps
// tst_pkg: widths, reset values, codes and control structs for the thermal step throttle
// used by tst_csr, tst_ctrl, tst_dp and thermal_step_throttle; no dependencies
package tst_pkg;

   // field widths
   localparam int FREQ_W      = 22;
   localparam int TEMP_W      = 9;
   localparam int THR_W       = 8;
   localparam int STEP_W      = 3;
   localparam int LEN_W       = 6;
   localparam int PTR_W       = 6;   // holds any index below the largest table depth
   localparam int EIX_W       = 5;
   localparam int MASK_W      = 4;
   localparam int CPU_PORTS   = 4;
   localparam int CPU_ID_W    = 2;
   localparam int LIM_OUT_W   = 5;
   localparam int PEND_W      = CPU_PORTS + 1;

   // stream and register port widths
   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 22;

   // build-time constants
   localparam int TABLE_DEPTH_DEF = 32;
   localparam int CPU_COUNT       = 4;

   // reset values
   localparam logic [THR_W-1:0]  TEMP_START_RST = 8'd65;
   localparam logic [THR_W-1:0]  TEMP_STOP_RST  = 8'd60;
   localparam logic [STEP_W-1:0] STEP_SIZE_RST  = 3'd1;
   localparam logic [FREQ_W-1:0] MIN_FREQ_RST   = 22'd378000;
   localparam logic [FREQ_W-1:0] MAX_FREQ_RST   = 22'd1890000;
   localparam logic [LEN_W-1:0]  TABLE_LEN_RST  = 6'd19;
   localparam logic [PTR_W-1:0]  LIMIT_RST      = 6'd18;
   localparam logic [PTR_W-1:0]  FLOOR_RST      = 6'd3;
   localparam logic [PTR_W-1:0]  CEIL_RST       = 6'd18;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TEMP_START   = 3'd0,
      CSR_TEMP_STOP    = 3'd1,
      CSR_STEP_SIZE    = 3'd2,
      CSR_MIN_FREQ     = 3'd3,
      CSR_MAX_FREQ     = 3'd4,
      CSR_TABLE_LENGTH = 3'd5
   } csr_idx_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_POLL = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_DOWN,
      MODE_HOLD,
      MODE_UP
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_SCAN,
      ST_STEP,
      ST_READ,
      ST_BUILD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [THR_W-1:0]  temp_start;
      logic [THR_W-1:0]  temp_stop;
      logic [STEP_W-1:0] step_size;
      logic [FREQ_W-1:0] min_freq;
      logic [FREQ_W-1:0] max_freq;
      logic [LEN_W-1:0]  table_length;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic capture;
      logic classify;
      logic scan;
      logic step;
      logic build;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic req_load;
      logic req_poll;
      logic active;
      logic need_scan;
      logic scan_done;
      logic build_empty;
      logic pending_empty;
      logic pop_last;
   } status_type;

endpackage

/* src/thermal_step_throttle.sv */
`timescale 1ns / 1ps
// thermal_step_throttle: top level of the table-driven thermal throttle with hysteresis
// depends on tst_pkg, tst_csr, tst_ctrl, tst_dp
//
//   channel  direction  handshake             contents
//   req_     in         tvalid/tready         tuser = operation, tdata = load or poll fields
//   rsp_     out        tvalid/tready/tlast   one cap or lift command per beat
//   csr_     in         we                    register write, index in csr_addr
//
// a load beat, or a poll with a failed sensor read, is taken without leaving idle
// a poll outside the throttle band (cold and not throttling) passes accept and classify
// other polls pass accept, classify, step, read and build, then emit 0 to 5 result beats;
// when throttling starts, a rescan of n = min(table_length, TABLE_DEPTH) entries, one per
// cycle through the table read port, precedes the step; req_tready is low until the last beat
// synchronous reset restores the registers and limit state; the table is not cleared
// rsp_tready low simply holds the current beat; no new poll is taken meanwhile
module thermal_step_throttle
   import tst_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,   // operation: 0 load, 1 poll
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // entry_index[4:0], entry_freq[26:5],
                                               // sensor_ok[27], temperature[36:28],
                                               // online_mask[40:37], cpu0_freq[62:41],
                                               // cpu1_freq[84:63], cpu2_freq[106:85],
                                               // cpu3_freq[128:107], zero pad above

   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic                   rsp_tlast,   // last command of this poll
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // target_cpu[1:0], cap_freq[23:2],
                                               // throttling[24], limit_index[29:25],
                                               // zero pad above

   // register writes
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg;     // live register values
   cmd_type    cmd;     // sequencer to datapath
   status_type status;  // datapath to sequencer

   tst_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer owns both handshakes
   tst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // table, limit state and the result register
   tst_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

/* src/tst_csr.sv */
`timescale 1ns / 1ps
// tst_csr: configuration registers of the thermal step throttle
// depends on tst_pkg
module tst_csr
   import tst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_start   <= TEMP_START_RST;
         cfg_ff.temp_stop    <= TEMP_STOP_RST;
         cfg_ff.step_size    <= STEP_SIZE_RST;
         cfg_ff.min_freq     <= MIN_FREQ_RST;
         cfg_ff.max_freq     <= MAX_FREQ_RST;
         cfg_ff.table_length <= TABLE_LEN_RST;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_TEMP_START:   cfg_ff.temp_start   <= csr_wdata[THR_W-1:0];
            CSR_TEMP_STOP:    cfg_ff.temp_stop    <= csr_wdata[THR_W-1:0];
            CSR_STEP_SIZE:    cfg_ff.step_size    <= csr_wdata[STEP_W-1:0];
            CSR_MIN_FREQ:     cfg_ff.min_freq     <= csr_wdata[FREQ_W-1:0];
            CSR_MAX_FREQ:     cfg_ff.max_freq     <= csr_wdata[FREQ_W-1:0];
            CSR_TABLE_LENGTH: cfg_ff.table_length <= csr_wdata[LEN_W-1:0];
            default: ;  // unused indexes are dropped
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/tst_ctrl.sv */
`timescale 1ns / 1ps
// tst_ctrl: sequencer of the thermal step throttle (accept, classify, scan, step, read, build, emit)
// depends on tst_pkg
module tst_ctrl
   import tst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && status.req_poll) state_in = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            if (!status.active)       state_in = ST_IDLE;
            else if (status.need_scan) state_in = ST_SCAN;
            else                       state_in = ST_STEP;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_STEP;
         end
         ST_STEP:  state_in = ST_READ;
         ST_READ:  state_in = ST_BUILD;
         ST_BUILD: begin
            state_in = status.build_empty ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_tready && status.pop_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      rsp_tvalid   = (state_ff == ST_EMIT);
      cmd.load     = req_tready && req_tvalid && status.req_load;
      cmd.capture  = req_tready && req_tvalid && status.req_poll;
      cmd.classify = (state_ff == ST_CLASSIFY);
      cmd.scan     = (state_ff == ST_SCAN);
      cmd.step     = (state_ff == ST_STEP);
      cmd.build    = (state_ff == ST_BUILD);
      cmd.pop      = rsp_tvalid && rsp_tready;
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input taken while a result beat is shown");

   a_emit_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !status.pending_empty)
      else $error("result beat shown with no pending command");

   a_empty_build: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUILD) && status.build_empty |=> req_tready)
      else $error("poll without commands did not return to idle");

endmodule

/* src/tst_dp.sv */
`timescale 1ns / 1ps
// tst_dp: datapath of the thermal step throttle: frequency table memory, limit state,
// floor/ceiling rescan, command list and result register; depends on tst_pkg
module tst_dp
   import tst_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  cfg_type                cfg,
   input  logic                   req_tuser,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output status_type             status,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // request beat layout
   localparam int EIX_LO  = 0;
   localparam int EFQ_LO  = EIX_LO + EIX_W;
   localparam int SOK_LO  = EFQ_LO + FREQ_W;
   localparam int TMP_LO  = SOK_LO + 1;
   localparam int MSK_LO  = TMP_LO + TEMP_W;
   localparam int CPU_LO  = MSK_LO + MASK_W;
   localparam int RSP_USED = CPU_ID_W + FREQ_W + 1 + LIM_OUT_W;

   // request fields
   logic [EIX_W-1:0]  req_eix;
   logic [FREQ_W-1:0] req_efreq;
   logic              req_sok;
   logic [TEMP_W-1:0] req_temp;
   logic [MASK_W-1:0] req_mask;

   assign req_eix   = req_tdata[EIX_LO +: EIX_W];
   assign req_efreq = req_tdata[EFQ_LO +: FREQ_W];
   assign req_sok   = req_tdata[SOK_LO];
   assign req_temp  = req_tdata[TMP_LO +: TEMP_W];
   assign req_mask  = req_tdata[MSK_LO +: MASK_W];

   // frequency table
   logic [FREQ_W-1:0] mem [TABLE_DEPTH];
   logic [PTR_W-1:0]  wr_idx;
   logic              wr_ok;
   logic [AW-1:0]     rd_addr;
   logic [FREQ_W-1:0] rd_data_ff;
   logic [AW-1:0]     rd_idx_ff;
   logic              rd_vld_ff;

   // poll state
   logic signed [TEMP_W-1:0] temp_ff;
   logic [MASK_W-1:0]        mask_ff;
   logic [FREQ_W-1:0]        cpu_freq_ff [CPU_PORTS];
   mode_type                 mode_ff;
   logic                     rescan_ff;
   logic                     lift_ff;
   logic [PTR_W-1:0]         limit_ff;
   logic [PTR_W-1:0]         floor_ff;
   logic [PTR_W-1:0]         ceil_ff;
   logic                     throttle_ff;
   logic [CNT_W-1:0]         scan_cnt_ff;
   logic [FREQ_W-1:0]        cap_ff;
   logic [PEND_W-1:0]        pending_ff;

   assign wr_idx = PTR_W'(req_eix);
   assign wr_ok  = ({1'b0, wr_idx} < (PTR_W + 1)'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (cmd.load && wr_ok) begin
         mem[wr_idx[AW-1:0]] <= req_efreq;
      end
   end

   // scan bound
   logic [CNT_W-1:0] scan_n;
   logic             scan_issue;

   assign scan_n = ({1'b0, cfg.table_length} > (LEN_W + 1)'(TABLE_DEPTH)) ?
                   CNT_W'(TABLE_DEPTH) : CNT_W'(cfg.table_length);
   assign status.scan_done = (scan_cnt_ff >= scan_n);
   assign scan_issue = cmd.scan && !status.scan_done;
   assign rd_addr = cmd.scan ? scan_cnt_ff[AW-1:0] : limit_ff[AW-1:0];

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      rd_idx_ff  <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         scan_cnt_ff <= '0;
      end else begin
         rd_vld_ff <= scan_issue;
         if (cmd.classify)    scan_cnt_ff <= '0;
         else if (scan_issue) scan_cnt_ff <= scan_cnt_ff + CNT_W'(1);
      end
   end

   // request decode
   assign status.req_load = (op_type'(req_tuser) == OP_LOAD);
   assign status.req_poll = (op_type'(req_tuser) == OP_POLL) && req_sok;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         temp_ff <= req_temp;
         mask_ff <= req_mask;
         for (int i = 0; i < CPU_PORTS; i++) begin
            cpu_freq_ff[i] <= req_tdata[CPU_LO + i * FREQ_W +: FREQ_W];
         end
      end
   end

   // threshold compare, temperature signed against unsigned thresholds
   logic     hot;
   logic     warm;
   mode_type mode_nxt;

   assign hot  = $signed({temp_ff[TEMP_W-1], temp_ff}) >= $signed({2'b00, cfg.temp_start});
   assign warm = $signed({temp_ff[TEMP_W-1], temp_ff}) >  $signed({2'b00, cfg.temp_stop});

   always_comb begin
      if (hot)                        mode_nxt = MODE_DOWN;
      else if (throttle_ff && warm)   mode_nxt = MODE_HOLD;
      else if (throttle_ff)           mode_nxt = MODE_UP;
      else                            mode_nxt = MODE_NONE;
   end

   assign status.active    = (mode_nxt != MODE_NONE);
   assign status.need_scan = hot && !throttle_ff;

   // limit step
   logic [PTR_W-1:0] base;
   logic [PTR_W+1:0] down_diff;
   logic             below;
   logic [PTR_W:0]   up_sum;
   logic             reach;

   assign base      = rescan_ff ? ceil_ff : limit_ff;
   assign down_diff = {2'b00, base} - {{(PTR_W + 2 - STEP_W){1'b0}}, cfg.step_size};
   assign below     = $signed(down_diff) < $signed({2'b00, floor_ff});
   assign up_sum    = {1'b0, base} + {{(PTR_W + 1 - STEP_W){1'b0}}, cfg.step_size};
   assign reach     = (up_sum >= {1'b0, ceil_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_NONE;
         rescan_ff   <= 1'b0;
         lift_ff     <= 1'b0;
         limit_ff    <= LIMIT_RST;
         floor_ff    <= FLOOR_RST;
         ceil_ff     <= CEIL_RST;
         throttle_ff <= 1'b0;
      end else begin
         if (cmd.classify) begin
            mode_ff   <= mode_nxt;
            rescan_ff <= status.need_scan;
         end
         // last match wins, entries arrive in index order
         if (rd_vld_ff) begin
            if (rd_data_ff == cfg.min_freq) floor_ff <= PTR_W'(rd_idx_ff);
            if (rd_data_ff == cfg.max_freq) ceil_ff  <= PTR_W'(rd_idx_ff);
         end
         if (cmd.step) begin
            lift_ff <= 1'b0;
            case (mode_ff)
               MODE_DOWN: begin
                  limit_ff    <= below ? floor_ff : down_diff[PTR_W-1:0];
                  throttle_ff <= 1'b1;
               end
               MODE_UP: begin
                  limit_ff <= reach ? ceil_ff : up_sum[PTR_W-1:0];
                  if (reach) begin
                     throttle_ff <= 1'b0;
                     lift_ff     <= 1'b1;
                  end
               end
               default: ;  // hold keeps the limit
            endcase
         end
      end
   end

   // command list: bit 0 lift, bit i+1 cap for cpu i
   logic              cap_ok;
   logic [FREQ_W-1:0] cap;
   logic [PEND_W-1:0] pending_nxt;
   logic [PEND_W-1:0] low_bit;
   logic [PEND_W-1:0] rest;
   logic [CPU_ID_W-1:0] tgt;
   logic [FREQ_W-1:0] out_cap;

   assign cap_ok = ({1'b0, limit_ff} < (PTR_W + 1)'(TABLE_DEPTH));
   assign cap    = cap_ok ? rd_data_ff : '0;

   always_comb begin
      pending_nxt[0] = lift_ff;
      for (int i = 0; i < CPU_PORTS; i++) begin
         pending_nxt[i + 1] = (i < CPU_COUNT) && mask_ff[i] &&
                              ((mode_ff == MODE_UP) || (cpu_freq_ff[i] != cap));
      end
   end

   assign status.build_empty = (pending_nxt == '0);

   assign low_bit = pending_ff & (~pending_ff + PEND_W'(1));
   assign rest    = pending_ff & ~low_bit;

   always_comb begin
      tgt = '0;
      for (int i = 0; i < CPU_PORTS; i++) begin
         if (low_bit[i + 1]) tgt = tgt | CPU_ID_W'(i);
      end
   end

   assign out_cap = low_bit[0] ? '0 : cap_ff;

   always_ff @(posedge clock) begin
      if (cmd.build) cap_ff <= cap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (cmd.build) begin
         pending_ff <= pending_nxt;
      end else if (cmd.pop) begin
         pending_ff <= rest;
      end
   end

   assign status.pending_empty = (pending_ff == '0);
   assign status.pop_last      = (rest == '0);

   assign rsp_tdata = {{(RSP_TDATA_W - RSP_USED){1'b0}}, limit_ff[LIM_OUT_W-1:0],
                       throttle_ff, out_cap, tgt};
   assign rsp_tlast = status.pop_last;

   a_pending_shrinks: assert property (@(posedge clock) disable iff (reset)
      (pending_ff != '0) |=> ((pending_ff & ~$past(pending_ff)) == '0))
      else $error("command list gained entries while being sent");

   a_down_throttles: assert property (@(posedge clock) disable iff (reset)
      cmd.step && (mode_ff == MODE_DOWN) |=> throttle_ff)
      else $error("step down left throttling off");

   a_lift_when_off: assert property (@(posedge clock) disable iff (reset)
      pending_ff[0] |-> !throttle_ff)
      else $error("lift command pending while still throttling");

endmodule

/* bench/thermal_step_throttle_tb.sv */
`timescale 1ns / 1ps
// thermal_step_throttle_tb: self-checking bench for the thermal step throttle
// drives table loads and temperature polls, predicts every cap and lift command
// depends on tst_pkg and thermal_step_throttle
module thermal_step_throttle_tb;
   import tst_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 80;
   localparam int LONG_HOLD     = 300;

   typedef enum {PACE_FLAT, PACE_MIXED, PACE_HEAVY} pace_type;
   typedef enum {SEG_HEAT, SEG_HOLD, SEG_COOL, SEG_NOISE} seg_type;

   typedef struct packed {
      op_type                             op;
      logic [CPU_PORTS-1:0][FREQ_W-1:0]   cpu_freq;
      logic [MASK_W-1:0]                  mask;
      logic [TEMP_W-1:0]                  temp;
      logic                               sensor_ok;
      logic [FREQ_W-1:0]                  entry_freq;
      logic [EIX_W-1:0]                   entry_index;
   } req_item_type;

   typedef struct packed {
      logic [CPU_ID_W-1:0]  cpu;
      logic [FREQ_W-1:0]    cap;
      logic                 throttling;
      logic [LIM_OUT_W-1:0] limit;
      logic                 is_last;
   } cmd_beat_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic                   req_tuser = 1'b0;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   rsp_tlast;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   thermal_step_throttle dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow of the throttle state and registers
   logic [FREQ_W-1:0] tbl_model [TABLE_DEPTH_DEF];
   int                lim_ptr   = int'(LIMIT_RST);
   int                floor_ix  = int'(FLOOR_RST);
   int                ceil_ix   = int'(CEIL_RST);
   logic              throttled = 1'b0;
   logic [THR_W-1:0]  cfg_start = TEMP_START_RST;
   logic [THR_W-1:0]  cfg_stop  = TEMP_STOP_RST;
   logic [STEP_W-1:0] cfg_step  = STEP_SIZE_RST;
   logic [FREQ_W-1:0] cfg_min   = MIN_FREQ_RST;
   logic [FREQ_W-1:0] cfg_max   = MAX_FREQ_RST;
   logic [LEN_W-1:0]  cfg_len   = TABLE_LEN_RST;

   req_item_type req_pending_q [$];
   cmd_beat_type cmd_expect_q [$];
   req_item_type req_cur;
   int        mismatch_count = 0;
   int        cycle_count = 0;
   pace_type  pace = PACE_FLAT;
   int        send_gap = 0;
   int        rsp_stall = 0;
   int        hold_asked = 0;
   int        hold_granted = 0;
   int        hold_left = 0;

   function automatic int draw_wait();
      case (pace)
         PACE_FLAT:  return 0;
         PACE_MIXED: return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
         default:    return $urandom_range(0, 18);
      endcase
   endfunction

   // work out the command beats one accepted item causes
   function automatic void predict_commands(input req_item_type it);
      int          t;
      int          n;
      int          i;
      mode_type    mode;
      logic [FREQ_W-1:0] cap;
      cmd_beat_type beats [$];
      cmd_beat_type b;
      if (it.op == OP_LOAD) begin
         tbl_model[it.entry_index] = it.entry_freq;
         return;
      end
      if (!it.sensor_ok) return;
      t = int'($signed(it.temp));
      if (t >= int'(cfg_start)) begin
         if (!throttled) begin
            // rescan: last match wins, no match keeps the old index
            n = (int'(cfg_len) > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(cfg_len);
            for (i = 0; i < n; i++) begin
               if (tbl_model[i] == cfg_min) floor_ix = i;
               if (tbl_model[i] == cfg_max) ceil_ix = i;
            end
            lim_ptr = ceil_ix;
         end
         throttled = 1'b1;
         lim_ptr -= int'(cfg_step);
         if (lim_ptr < floor_ix) lim_ptr = floor_ix;
         mode = MODE_DOWN;
      end else if (throttled && t > int'(cfg_stop)) begin
         mode = MODE_HOLD;
      end else if (throttled) begin
         lim_ptr += int'(cfg_step);
         if (lim_ptr >= ceil_ix) begin
            lim_ptr = ceil_ix;
            throttled = 1'b0;
            b = '0;
            beats.push_back(b);   // lift-limit command
         end
         mode = MODE_UP;
      end else begin
         mode = MODE_NONE;
      end
      if (mode != MODE_NONE) begin
         cap = (lim_ptr >= 0 && lim_ptr < TABLE_DEPTH_DEF) ? tbl_model[lim_ptr] : '0;
         for (i = 0; i < CPU_COUNT && i < CPU_PORTS; i++) begin
            if (!it.mask[i]) continue;
            if (mode != MODE_UP && it.cpu_freq[i] == cap) continue;
            b = '0;
            b.cpu = CPU_ID_W'(i);
            b.cap = cap;
            beats.push_back(b);
         end
      end
      for (i = 0; i < beats.size(); i++) begin
         b = beats[i];
         b.throttling = throttled;
         b.limit = LIM_OUT_W'(lim_ptr);
         b.is_last = (i == beats.size() - 1);
         cmd_expect_q.push_back(b);
      end
   endfunction

   function automatic req_item_type load_item(input int idx, input logic [FREQ_W-1:0] f);
      req_item_type it;
      it.op = OP_LOAD;
      it.entry_index = EIX_W'(idx);
      it.entry_freq = f;
      it.sensor_ok = 1'($urandom());
      it.temp = TEMP_W'($urandom());
      it.mask = MASK_W'($urandom());
      for (int i = 0; i < CPU_PORTS; i++) it.cpu_freq[i] = FREQ_W'($urandom());
      return it;
   endfunction

   function automatic req_item_type poll_item(input logic ok, input int t,
                                              input logic [MASK_W-1:0] m,
                                              input logic [FREQ_W-1:0] f0, f1, f2, f3);
      req_item_type it;
      it.op = OP_POLL;
      it.entry_index = EIX_W'($urandom());
      it.entry_freq = FREQ_W'($urandom());
      it.sensor_ok = ok;
      it.temp = TEMP_W'(t);
      it.mask = m;
      it.cpu_freq = {f3, f2, f1, f0};
      return it;
   endfunction

   // table entries of the directed part
   function automatic logic [FREQ_W-1:0] grid_freq(input int i);
      return FREQ_W'(378000 + 84000 * i);
   endfunction

   // half the draws are values near the current cap, so both the skip and the issue path show up
   function automatic logic [FREQ_W-1:0] pick_cpu_freq();
      int off;
      int idx;
      case ($urandom_range(0, 5))
         0, 1, 2: begin
            off = $urandom_range(0, 2);
            idx = lim_ptr + (off - 1) * int'(cfg_step);
            if (idx < 0) idx = 0;
            if (idx > TABLE_DEPTH_DEF - 1) idx = TABLE_DEPTH_DEF - 1;
            return tbl_model[idx];
         end
         3:       return ($urandom_range(0, 1) != 0) ? {FREQ_W{1'b1}} : '0;
         default: return FREQ_W'($urandom());
      endcase
   endfunction

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   task automatic write_reg(input csr_idx_type a, input logic [CSR_DATA_W-1:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= a;
      csr_wdata <= v;
      case (a)
         CSR_TEMP_START:   cfg_start = v[THR_W-1:0];
         CSR_TEMP_STOP:    cfg_stop = v[THR_W-1:0];
         CSR_STEP_SIZE:    cfg_step = v[STEP_W-1:0];
         CSR_MIN_FREQ:     cfg_min = v[FREQ_W-1:0];
         CSR_MAX_FREQ:     cfg_max = v[FREQ_W-1:0];
         CSR_TABLE_LENGTH: cfg_len = v[LEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input int ts, input int tp, input int st,
                                input logic [FREQ_W-1:0] mn, input logic [FREQ_W-1:0] mx,
                                input int ln);
      write_reg(CSR_TEMP_START, CSR_DATA_W'(ts));
      write_reg(CSR_TEMP_STOP, CSR_DATA_W'(tp));
      write_reg(CSR_STEP_SIZE, CSR_DATA_W'(st));
      write_reg(CSR_MIN_FREQ, mn);
      write_reg(CSR_MAX_FREQ, mx);
      write_reg(CSR_TABLE_LENGTH, CSR_DATA_W'(ln));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // wait until nothing is in flight, then let a silent poll run out
   task automatic settle();
      while (req_pending_q.size() != 0 || req_tvalid || cmd_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // heat, hold and cool runs around the thresholds, with loads and noise mixed in
   task automatic build_phase(input int count);
      int                made;
      int                seg_len;
      int                k;
      int                roll;
      int                t;
      int                lo;
      int                hi;
      seg_type           seg;
      logic [MASK_W-1:0] m;
      logic [FREQ_W-1:0] f;
      made = 0;
      while (made < count) begin
         seg = seg_type'($urandom_range(0, 3));
         seg_len = $urandom_range(1, 10);
         for (k = 0; k < seg_len && made < count; k++) begin
            while (req_pending_q.size() >= 2) @(posedge clock);
            roll = $urandom_range(0, 19);
            if (roll < 2) begin
               case ($urandom_range(0, 3))
                  0:       f = cfg_min;
                  1:       f = cfg_max;
                  default: f = FREQ_W'($urandom());
               endcase
               req_pending_q.push_back(load_item($urandom_range(0, TABLE_DEPTH_DEF - 1), f));
            end else begin
               case (seg)
                  SEG_HEAT: begin
                     t = int'(cfg_start) + int'($urandom_range(0, 4));
                     if (t > 255) t = 255;
                  end
                  SEG_HOLD: begin
                     lo = int'(cfg_stop) + 1;
                     hi = int'(cfg_start) - 1;
                     if (lo <= hi) t = lo + int'($urandom_range(0, hi - lo));
                     else t = int'($urandom_range(0, 383)) - 128;
                  end
                  SEG_COOL: begin
                     t = int'(cfg_stop) - int'($urandom_range(0, 6));
                     if (t < -128) t = -128;
                  end
                  default: begin
                     if ($urandom_range(0, 3) == 0) t = ($urandom_range(0, 1) != 0) ? 255 : -128;
                     else t = int'($urandom_range(0, 383)) - 128;
                  end
               endcase
               if (roll == 3) t = int'($urandom_range(0, 383)) - 128;
               m = ($urandom_range(0, 3) == 0) ? {MASK_W{1'b1}} : MASK_W'($urandom());
               req_pending_q.push_back(poll_item(roll != 2, t, m, pick_cpu_freq(),
                                                 pick_cpu_freq(), pick_cpu_freq(),
                                                 pick_cpu_freq()));
            end
            made++;
         end
      end
   endtask

   // request driver: one beat at a time from the pending queue
   always @(posedge clock) begin
      logic offer;
      offer = req_tvalid;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_commands(req_cur);
            offer = 1'b0;
            send_gap = draw_wait();
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (req_pending_q.size() > 0) begin
               req_cur = req_pending_q.pop_front();
               req_tuser <= req_cur.op;
               req_tdata <= {7'd0, req_cur.cpu_freq, req_cur.mask, req_cur.temp,
                             req_cur.sensor_ok, req_cur.entry_freq, req_cur.entry_index};
               offer = 1'b1;
            end
         end
         req_tvalid <= offer;
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_asked != hold_granted) begin
         hold_granted = hold_asked;
         hold_left <= LONG_HOLD;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor: compare each beat with the oldest predicted command
   always @(posedge clock) begin
      cmd_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (cmd_expect_q.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual tdata %h tlast %b",
                        $time, rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               want = cmd_expect_q.pop_front();
               check_field("target_cpu", want.cpu, rsp_tdata[1:0]);
               check_field("cap_freq", want.cap, rsp_tdata[23:2]);
               check_field("throttling", want.throttling, rsp_tdata[24]);
               check_field("limit_index", want.limit, rsp_tdata[29:25]);
               check_field("tlast", want.is_last, rsp_tlast);
            end
            rsp_stall = draw_wait();
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_tready <= (rsp_stall == 0) && (hold_left == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int                i;
      int                p;
      logic [FREQ_W-1:0] r0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // fill the whole table first so no read ever sees an unwritten entry;
      // entry 25 repeats the ceiling value, 30 and 31 hold the frequency extremes
      for (i = 0; i < TABLE_DEPTH_DEF; i++) begin
         if (i == 25) r0 = MAX_FREQ_RST;
         else if (i == 30) r0 = '0;
         else if (i == 31) r0 = {FREQ_W{1'b1}};
         else r0 = grid_freq(i);
         req_pending_q.push_back(load_item(i, r0));
      end

      // reset settings: failed read, cold polls, throttle entry, hold, step up to lift
      req_pending_q.push_back(poll_item(1'b0, 100, 4'hF, 0, 0, 0, 0));
      req_pending_q.push_back(poll_item(1'b1, -128, 4'hF, 0, 0, 0, 0));
      req_pending_q.push_back(poll_item(1'b1, 64, 4'hF, 0, 0, 0, 0));
      req_pending_q.push_back(poll_item(1'b1, 65, 4'hF, grid_freq(17), 0,
                                        {FREQ_W{1'b1}}, grid_freq(17)));
      req_pending_q.push_back(poll_item(1'b1, 255, 4'b1010, FREQ_W'($urandom()),
                                        FREQ_W'($urandom()), FREQ_W'($urandom()),
                                        FREQ_W'($urandom())));
      req_pending_q.push_back(poll_item(1'b1, 62, 4'hF, grid_freq(16), grid_freq(16),
                                        grid_freq(16), grid_freq(16)));
      req_pending_q.push_back(poll_item(1'b1, 61, 4'b0100, grid_freq(16), grid_freq(16),
                                        grid_freq(15), grid_freq(16)));
      req_pending_q.push_back(poll_item(1'b1, 60, 4'h0, 0, 0, 0, 0));
      req_pending_q.push_back(poll_item(1'b1, -1, 4'hF, grid_freq(18), grid_freq(18),
                                        grid_freq(18), grid_freq(18)));
      req_pending_q.push_back(poll_item(1'b1, 61, 4'hF, 0, 0, 0, 0));
      settle();

      // extremes: floor lands above the ceiling, long step, oversized table length
      apply_setting(255, 0, 7, {FREQ_W{1'b1}}, '0, 63);
      req_pending_q.push_back(poll_item(1'b1, 255, 4'hF, {FREQ_W{1'b1}}, FREQ_W'($urandom()),
                                        FREQ_W'($urandom()), FREQ_W'($urandom())));
      req_pending_q.push_back(poll_item(1'b1, 100, 4'hF, {FREQ_W{1'b1}}, 0, 0, 0));
      req_pending_q.push_back(poll_item(1'b1, 0, 4'b0001, 0, 0, 0, 0));
      req_pending_q.push_back(poll_item(1'b1, -128, 4'hF, 0, 0, 0, 0));
      settle();

      // zero step and an empty scan keep the old floor and ceiling
      apply_setting(0, 255, 0, MIN_FREQ_RST, MAX_FREQ_RST, 0);
      req_pending_q.push_back(poll_item(1'b1, 0, 4'hF, 0, 0, 0, 0));
      req_pending_q.push_back(poll_item(1'b1, -1, 4'hF, 0, 0, 0, 0));
      settle();

      // random phases, each under its own setting
      for (p = 0; p < 8; p++) begin
         case (p)
            0: begin
               apply_setting(TEMP_START_RST, TEMP_STOP_RST, STEP_SIZE_RST, MIN_FREQ_RST,
                             MAX_FREQ_RST, TABLE_LEN_RST);
               pace = PACE_FLAT;
            end
            1: begin
               apply_setting(255, 0, 7, '0, {FREQ_W{1'b1}}, 63);
               pace = PACE_HEAVY;
               hold_asked++;   // receiver stalls while polls keep coming
            end
            2: begin
               apply_setting(0, 255, 0, MIN_FREQ_RST, MAX_FREQ_RST, 0);
               pace = PACE_MIXED;
            end
            3: begin
               apply_setting(40, 90, 3, MIN_FREQ_RST, MAX_FREQ_RST, 32);
               pace = PACE_HEAVY;
            end
            4: begin
               apply_setting(90, 30, 5, tbl_model[0], tbl_model[TABLE_DEPTH_DEF - 1], 1);
               pace = PACE_MIXED;
            end
            default: begin
               apply_setting($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 7),
                             tbl_model[$urandom_range(0, TABLE_DEPTH_DEF - 1)],
                             tbl_model[$urandom_range(0, TABLE_DEPTH_DEF - 1)],
                             $urandom_range(0, 63));
               pace = pace_type'($urandom_range(0, 2));
            end
         endcase
         build_phase(40);
         settle();
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* thermal_step_throttle.f */
src/tst_pkg.sv
src/tst_csr.sv
src/tst_ctrl.sv
src/tst_dp.sv
src/thermal_step_throttle.sv
bench/thermal_step_throttle_tb.sv
